### rtl/core/kef_pkg.sv
// Shared types and constants for the Kruskal edge union-find block.
// Holds the request and result payload structs and the queue entry type.
// No dependencies.
package kef_pkg;

    localparam int VERTICES    = 1024;
    localparam int VIDX_W      = $clog2(VERTICES);
    localparam int VERT_W      = 10;
    localparam int WEIGHT_W    = 16;
    localparam int COST_W      = 27;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef logic [VIDX_W-1:0] vidx_t;

    typedef struct packed {
        logic [VERT_W-1:0]   vertex_a;
        logic [VERT_W-1:0]   vertex_b;
        logic [WEIGHT_W-1:0] weight;
        logic                last_edge;
    } edge_t;

    typedef struct packed {
        logic              accepted;
        logic [VERT_W-1:0] tree_a;
        logic [VERT_W-1:0] tree_b;
        logic [COST_W-1:0] total_cost;
        logic              graph_done;
    } result_t;

    // One queued request after classification by the front end.
    typedef struct packed {
        edge_t edge_item;
        vidx_t idx_a;
        vidx_t idx_b;
        logic  self_loop;
    } job_t;

    // Endpoints beyond the store wrap around modulo the vertex count.
    function automatic vidx_t to_index(input logic [VERT_W-1:0] v);
        return vidx_t'(v % VERTICES);
    endfunction

endpackage

### rtl/core/kef_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module kef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/kef_front.sv
// Front end: accepts edge requests, reduces endpoints to store indexes, flags
// self loops and holds them in a short queue for the back end.
// Depends on kef_pkg.
module kef_front
    import kef_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  edge_valid,
    output logic  edge_ready,
    input  edge_t edge_data,
    output logic  job_valid,
    output job_t  job,
    input  logic  pop
);

    job_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              push;
    job_t              incoming;

    assign edge_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = edge_valid && edge_ready;
    assign job_valid  = (cnt_reg != '0);
    assign job        = q_reg[rd_ptr_reg];

    always_comb
    begin
        incoming.edge_item = edge_data;
        incoming.idx_a     = to_index(edge_data.vertex_a);
        incoming.idx_b     = to_index(edge_data.vertex_b);
        incoming.self_loop = (incoming.idx_a == incoming.idx_b);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue popped while empty");
`endif

endmodule

### rtl/core/kef_back.sv
// Back end: walks both endpoints to their roots in the parent memory, joins
// the sets, keeps the saturating cost and drives the result register.
// Depends on kef_pkg and kef_ram.
module kef_back
    import kef_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    input  job_t    job,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_A,
        S_FIND_B,
        S_FINISH
    } state_t;

    state_t            state_reg,     state_next;
    vidx_t             clr_reg,       clr_next;
    vidx_t             node_reg,      node_next;
    vidx_t             root_a_reg,    root_a_next;
    job_t              cur_reg,       cur_next;
    logic              acc_reg,       acc_next;
    logic [COST_W-1:0] cost_reg,      cost_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg,       out_next;

    logic              we;
    vidx_t             waddr;
    vidx_t             wdata;
    vidx_t             raddr;
    vidx_t             rdata;
    logic              out_free;
    logic              can_start;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] new_cost;

    kef_ram #(
        .WIDTH (VIDX_W),
        .DEPTH (VERTICES)
    ) u_parent (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || result_ready;
    assign sum      = {1'b0, cost_reg} + (COST_W + 1)'(cur_reg.edge_item.weight);
    assign new_cost = !acc_reg ? cost_reg
                    : (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        root_a_next    = root_a_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        cost_next      = cost_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = node_reg;
        wdata          = node_reg;
        raddr          = node_reg;
        pop            = 1'b0;
        can_start      = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Every entry becomes its own root again.
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == vidx_t'(VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                can_start = 1'b1;
            end
            S_FIND_A:
            begin
                if (rdata == node_reg)
                begin
                    root_a_next = node_reg;
                    if (cur_reg.idx_a != node_reg)
                    begin
                        we    = 1'b1;
                        waddr = cur_reg.idx_a;
                        wdata = node_reg;
                    end
                    raddr      = cur_reg.idx_b;
                    node_next  = cur_reg.idx_b;
                    state_next = S_FIND_B;
                end
                else
                begin
                    raddr     = rdata;
                    node_next = rdata;
                end
            end
            S_FIND_B:
            begin
                if (rdata == node_reg)
                begin
                    we = 1'b1;
                    if (node_reg != root_a_reg)
                    begin
                        // Link the root of b under the root of a.
                        acc_next = 1'b1;
                        waddr    = node_reg;
                        wdata    = root_a_reg;
                    end
                    else
                    begin
                        acc_next = 1'b0;
                        waddr    = cur_reg.idx_b;
                        wdata    = node_reg;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    raddr     = rdata;
                    node_next = rdata;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.accepted   = acc_reg;
                    out_next.tree_a     = cur_reg.edge_item.vertex_a;
                    out_next.tree_b     = cur_reg.edge_item.vertex_b;
                    out_next.total_cost = new_cost;
                    out_next.graph_done = cur_reg.edge_item.last_edge;
                    if (cur_reg.edge_item.last_edge)
                    begin
                        cost_next  = '0;
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        cost_next  = new_cost;
                        state_next = S_IDLE;
                        can_start  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        if (can_start && job_valid)
        begin
            pop       = 1'b1;
            cur_next  = job;
            node_next = job.idx_a;
            raddr     = job.idx_a;
            if (job.self_loop)
            begin
                acc_next   = 1'b0;
                state_next = S_FINISH;
            end
            else
            begin
                state_next = S_FIND_A;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            node_reg      <= '0;
            root_a_reg    <= '0;
            cur_reg       <= '0;
            acc_reg       <= 1'b0;
            cost_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            node_reg      <= node_next;
            root_a_reg    <= root_a_next;
            cur_reg       <= cur_next;
            acc_reg       <= acc_next;
            cost_reg      <= cost_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !pop)
        else $error("request taken during the clearing pass");

    a_cost_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR && $past(state_reg) != S_CLEAR) |-> cost_reg >= $past(cost_reg))
        else $error("running cost decreased within a graph");

    a_accept_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.accepted) |-> result_data.tree_a != result_data.tree_b)
        else $error("self loop reported as accepted");
`endif

endmodule

### rtl/core/kruskal_edge_union_find.sv
// Kruskal edge processor: union-find over a 1024-entry parent memory.
// In the back end an edge walks both endpoints to their roots, one parent memory
// read per hop; a self loop skips the walk and goes straight to the finish state.
// After reset and after each last edge, a clearing pass rewrites the whole
// parent memory before the next request is processed.
module kruskal_edge_union_find
    import kef_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    edge_valid,
    output logic    edge_ready,
    input  edge_t   edge_data,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result_data
);

    logic job_valid;
    job_t job;
    logic pop;

    kef_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_valid),
        .edge_ready (edge_ready),
        .edge_data  (edge_data),
        .job_valid  (job_valid),
        .job        (job),
        .pop        (pop)
    );

    kef_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

### test/kruskal_edge_union_find_tb.sv
// Testbench for kruskal_edge_union_find: a directed table of edges, then random graphs
// with random stalls on both sides. Results are checked against a union-find predictor in
// this file, or typed-in values for pinned rows. Depends on kef_pkg and the block itself.
module kruskal_edge_union_find_tb;
    import kef_pkg::*;

    localparam int CYCLE_LIMIT  = 5000000;
    localparam int RANDOM_EDGES = 1030;
    localparam int CALM_TAIL    = 150;
    localparam int BACKLOG_HOLD = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int DIRECTED_N   = 20;

    // One directed request; acc and cost are only meaningful when pinned is set.
    typedef struct {
        int a;
        int b;
        int w;
        int last;
        bit pinned;
        int acc;
        int cost;
    } edge_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    edge_valid = 1'b0;
    logic    edge_ready;
    edge_t   edge_data = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result_data;

    // Typed-in expectation that travels with the current request.
    logic    pin_valid = 1'b0;
    result_t pin_result = '0;

    logic idle_on = 1'b1;
    bit   sender_idles = 1'b1;
    int   hold_requests = 0;

    vidx_t             link_of [VERTICES];
    logic [COST_W-1:0] cost_sum;
    result_t           pending_results [$];

    int edges_sent = 0;
    int results_checked = 0;
    int trees_joined = 0;
    int graphs_closed = 0;
    int mismatches = 0;
    int cycle_count = 0;

    kruskal_edge_union_find u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_ready   (edge_ready),
        .edge_data    (edge_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_forest();
        for (int i = 0; i < VERTICES; i++)
        begin
            link_of[i] = vidx_t'(i);
        end
        cost_sum = '0;
    endfunction

    function automatic vidx_t find_root(input vidx_t v);
        vidx_t r;
        vidx_t nxt;
        r = v;
        while (link_of[r] != r)
        begin
            r = link_of[r];
        end
        while (v != r)
        begin
            nxt = link_of[v];
            link_of[v] = r;
            v = nxt;
        end
        return r;
    endfunction

    function automatic result_t predict_edge(input edge_t e);
        vidx_t         ra;
        vidx_t         rb;
        logic [COST_W:0] sum;
        result_t       r;
        ra = find_root(vidx_t'(e.vertex_a % VERTICES));
        rb = find_root(vidx_t'(e.vertex_b % VERTICES));
        r.accepted = (ra != rb);
        if (ra != rb)
        begin
            sum = {1'b0, cost_sum} + (COST_W + 1)'(e.weight);
            cost_sum = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];
            link_of[rb] = ra;
        end
        r.tree_a = e.vertex_a;
        r.tree_b = e.vertex_b;
        r.total_cost = cost_sum;
        r.graph_done = e.last_edge;
        if (e.last_edge)
        begin
            clear_forest();
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Requests are predicted in acceptance order; results are matched to the oldest one.
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n)
        begin
            if (edge_valid && edge_ready)
            begin
                want = predict_edge(edge_data);
                pending_results = {pending_results, (pin_valid ? pin_result : want)};
            end
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time,
                             result_data);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(result_data.accepted));
                    check_field("tree_a", 32'(want.tree_a), 32'(result_data.tree_a));
                    check_field("tree_b", 32'(want.tree_b), 32'(result_data.tree_b));
                    check_field("total_cost", 32'(want.total_cost),
                                32'(result_data.total_cost));
                    check_field("graph_done", 32'(want.graph_done),
                                32'(result_data.graph_done));
                    results_checked++;
                    if (result_data.accepted)
                    begin
                        trees_joined++;
                    end
                    if (result_data.graph_done)
                    begin
                        graphs_closed++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request from the sender.
    initial
    begin : result_sink
        int gap;
        int holds_done;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                result_ready <= 1'b0;
                repeat (BACKLOG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 9);
                result_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic offer_edge(input edge_t e, input logic pinned, input result_t want);
        int gap;
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            edge_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_valid <= 1'b1;
        edge_data <= e;
        pin_valid <= pinned;
        pin_result <= want;
        @(posedge clk);
        while (edge_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        edges_sent++;
    endtask

    task automatic wait_for_results();
        edge_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    initial
    begin : stimulus
        edge_row_t directed [DIRECTED_N];
        edge_t     e;
        result_t   want;
        int        random_sent;
        int        graph_no;
        int        count;
        int        span;
        int        base;
        int        w;
        bit        noisy;

        directed = '{
            '{0,    1023, 65535, 0, 1, 1, 65535},
            '{1023, 0,    65535, 0, 1, 0, 65535},
            '{5,    5,    65535, 0, 1, 0, 65535},
            '{1023, 1023, 65535, 0, 1, 0, 65535},
            '{512,  1,    65535, 0, 1, 1, 131070},
            '{1,    0,    65535, 0, 1, 1, 196605},
            '{1023, 512,  65535, 0, 1, 0, 196605},
            '{2,    3,    100,   0, 1, 1, 196705},
            '{3,    2,    0,     1, 1, 0, 196705},
            '{0,    1023, 0,     0, 1, 1, 0},
            '{682,  341,  43690, 0, 1, 1, 43690},
            '{341,  682,  21845, 0, 1, 0, 43690},
            '{11,   10,   1,     0, 0, 0, 0},
            '{12,   11,   2,     0, 0, 0, 0},
            '{13,   12,   3,     0, 0, 0, 0},
            '{14,   13,   4,     0, 0, 0, 0},
            '{10,   14,   5,     0, 0, 0, 0},
            '{10,   0,    6,     0, 0, 0, 0},
            '{14,   1023, 7,     1, 0, 0, 0},
            '{1023, 0,    65535, 1, 1, 1, 65535}
        };

        clear_forest();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            e.vertex_a = VERT_W'(directed[i].a);
            e.vertex_b = VERT_W'(directed[i].b);
            e.weight = WEIGHT_W'(directed[i].w);
            e.last_edge = 1'(directed[i].last);
            want.accepted = 1'(directed[i].acc);
            want.tree_a = e.vertex_a;
            want.tree_b = e.vertex_b;
            want.total_cost = COST_W'(directed[i].cost);
            want.graph_done = e.last_edge;
            offer_edge(e, directed[i].pinned, want);
        end

        // Mostly well-formed graphs: clustered vertices, nondecreasing weights, a closing
        // last edge. Now and then a noisy graph with unsorted weights and stray last edges.
        random_sent = 0;
        graph_no = 0;
        while (random_sent < RANDOM_EDGES)
        begin
            if (graph_no == 4)
            begin
                hold_requests <= hold_requests + 1;
            end
            if (graph_no == 8)
            begin
                wait_for_results();
            end
            if (RANDOM_EDGES - random_sent <= CALM_TAIL)
            begin
                sender_idles = 1'b0;
            end
            else
            begin
                sender_idles = ($urandom_range(0, 3) != 0);
            end
            idle_on <= sender_idles;

            noisy = ($urandom_range(0, 6) == 0);
            span = (graph_no == 12) ? VERTICES : $urandom_range(2, 64);
            count = (graph_no == 12) ? 200 : $urandom_range(2, 40);
            base = $urandom_range(0, VERTICES - span);
            w = $urandom_range(0, 65535);
            for (int k = 0; k < count; k++)
            begin
                if (noisy)
                begin
                    e.vertex_a = VERT_W'($urandom_range(0, 1023));
                    e.vertex_b = VERT_W'($urandom_range(0, 1023));
                    e.weight = WEIGHT_W'($urandom_range(0, 65535));
                    e.last_edge = ($urandom_range(0, 7) == 0);
                end
                else
                begin
                    e.vertex_a = VERT_W'(base + $urandom_range(0, span - 1));
                    if ($urandom_range(0, 15) == 0)
                    begin
                        e.vertex_b = e.vertex_a;
                    end
                    else
                    begin
                        e.vertex_b = VERT_W'(base + $urandom_range(0, span - 1));
                    end
                    w = w + $urandom_range(0, 1500);
                    if (w > 65535)
                    begin
                        w = 65535;
                    end
                    e.weight = WEIGHT_W'(w);
                    e.last_edge = (k == count - 1);
                end
                offer_edge(e, 1'b0, '0);
                random_sent++;
            end
            graph_no++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d edges in %0d graphs (%0d random).",
                 results_checked, edges_sent, graph_no, random_sent);
        $display("Edges that joined two sets: %0d, graph ends seen: %0d.",
                 trees_joined, graphs_closed);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### kruskal_edge_union_find.f
rtl/core/kef_pkg.sv
rtl/core/kef_ram.sv
rtl/core/kef_front.sv
rtl/core/kef_back.sv
rtl/core/kruskal_edge_union_find.sv
test/kruskal_edge_union_find_tb.sv
